// ===== rtl/core/mwm_pkg.sv =====
`default_nettype none

package mwm_pkg;

  // Fixed field widths
  localparam int unsigned REG_W   = 12;
  localparam int unsigned VEL_W   = 16;
  localparam int unsigned WHEEL_W = 25;
  localparam int unsigned MAG_W   = 24;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CIDX_W  = 2;

  localparam int unsigned FRAC_BITS_DEF = 12;

  localparam logic [MAG_W-1:0] WHEEL_MAX = 24'hFF_FFFF;

  // Opcodes
  localparam logic [OP_W-1:0] OP_DRIVE = 2'd0;
  localparam logic [OP_W-1:0] OP_BRAKE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_HALF_TRACK = 2'd0;
  localparam logic [CIDX_W-1:0] REG_CIRCUMF    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_DECAY      = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SNAP       = 2'd3;

  // Register reset values
  localparam logic [REG_W-1:0] HALF_TRACK_RST = 12'd692;
  localparam logic [REG_W-1:0] CIRCUMF_RST    = 12'd1029;
  localparam logic [REG_W-1:0] DECAY_RST      = 12'd205;
  localparam logic [REG_W-1:0] SNAP_RST       = 12'd41;

  localparam logic [1:0] LANE_LAST = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic       load_vel;
    logic       set_brake;
    logic       decay_mul;
    logic       decay_apply;
    logic       kw_mul;
    logic       div_start;
    logic       div_step;
    logic       div_store;
    logic       out_load;
    logic [1:0] lane;
  } mwm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic brake_active;
  } mwm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mwm_ctrl.sv =====
`default_nettype none

module mwm_ctrl
  import mwm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [OP_W-1:0] opcode_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire mwm_sts_t        sts_i,
  output mwm_cmd_t             cmd_o
);

  localparam int unsigned NUM_W = REG_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DMUL   = 4'd1;
  localparam logic [3:0] S_DAPPLY = 4'd2;
  localparam logic [3:0] S_KW     = 4'd3;
  localparam logic [3:0] S_DSTART = 4'd4;
  localparam logic [3:0] S_DSTEP  = 4'd5;
  localparam logic [3:0] S_DSTORE = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  logic [3:0]       state_q, state_d;
  logic [1:0]       lane_q, lane_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             in_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.lane  = lane_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (opcode_i)
            OP_DRIVE: begin
              cmd_o.load_vel = 1'b1;
              state_d        = S_KW;
            end
            OP_BRAKE: begin
              cmd_o.set_brake = 1'b1;
            end
            OP_TICK: begin
              if (sts_i.brake_active) begin
                state_d = S_DMUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DMUL: begin
        cmd_o.decay_mul = 1'b1;
        state_d         = S_DAPPLY;
      end
      S_DAPPLY: begin
        cmd_o.decay_apply = 1'b1;
        state_d           = S_KW;
      end
      S_KW: begin
        cmd_o.kw_mul = 1'b1;
        lane_d       = '0;
        state_d      = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        cnt_d           = '0;
        state_d         = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd_o.div_store = 1'b1;
        if (lane_q == LANE_LAST) begin
          state_d = S_OUT;
        end else begin
          lane_d  = lane_q + 1'b1;
          state_d = S_DSTART;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lane_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane_q      <= lane_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mwm_datapath.sv =====
`default_nettype none

module mwm_datapath
  import mwm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CIDX_W-1:0]        cfg_index_i,
  input  wire logic [REG_W-1:0]         cfg_data_i,
  input  wire logic signed [VEL_W-1:0]  vel_x_i,
  input  wire logic signed [VEL_W-1:0]  vel_y_i,
  input  wire logic signed [VEL_W-1:0]  yaw_rate_i,
  input  wire mwm_cmd_t                 cmd_i,
  output mwm_sts_t                      sts_o,
  output logic signed [WHEEL_W-1:0]     wheel_one_o,
  output logic signed [WHEEL_W-1:0]     wheel_two_o,
  output logic signed [WHEEL_W-1:0]     wheel_three_o,
  output logic signed [WHEEL_W-1:0]     wheel_four_o,
  output logic                          braking_o
);

  localparam int unsigned PROD_W = REG_W + VEL_W + 1;
  localparam int unsigned KW_W   = PROD_W - FRAC_BITS;
  localparam int unsigned SUM_W  = VEL_W + 1;
  localparam int unsigned DIV_W  = ((KW_W > SUM_W) ? KW_W : SUM_W) + 1;
  localparam int unsigned RED_W  = ((KW_W > VEL_W) ? KW_W : VEL_W) + 1;
  localparam int unsigned NUM_W  = REG_W + FRAC_BITS;

  // Configuration registers
  logic [REG_W-1:0] half_track_q, circumf_q, decay_q, snap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_track_q <= HALF_TRACK_RST;
      circumf_q    <= CIRCUMF_RST;
      decay_q      <= DECAY_RST;
      snap_q       <= SNAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HALF_TRACK: half_track_q <= cfg_data_i;
        REG_CIRCUMF:    circumf_q    <= cfg_data_i;
        REG_DECAY:      decay_q      <= cfg_data_i;
        REG_SNAP:       snap_q       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Chassis state
  logic signed [VEL_W-1:0] speed_x_q, speed_y_q, speed_turn_q;
  logic                    brake_q;

  assign sts_o.brake_active = brake_q;

  // Brake decay: products registered, then subtract and snap
  logic signed [REG_W:0]    decay_s, half_track_s;
  logic signed [PROD_W-1:0] prod_x_d, prod_y_d, prod_kw;
  logic signed [PROD_W-1:0] prod_x_q, prod_y_q;
  logic signed [RED_W-1:0]  red_x, red_y, snap_s;
  logic signed [VEL_W-1:0]  new_x, new_y;

  assign decay_s      = $signed({1'b0, decay_q});
  assign half_track_s = $signed({1'b0, half_track_q});
  assign prod_x_d     = decay_s * speed_x_q;
  assign prod_y_d     = decay_s * speed_y_q;
  assign prod_kw      = half_track_s * speed_turn_q;

  assign snap_s = $signed(RED_W'(snap_q));
  assign red_x  = RED_W'(speed_x_q) - RED_W'(KW_W'(prod_x_q >>> FRAC_BITS));
  assign red_y  = RED_W'(speed_y_q) - RED_W'(KW_W'(prod_y_q >>> FRAC_BITS));
  assign new_x  = (red_x <= snap_s) ? '0 : red_x[VEL_W-1:0];
  assign new_y  = (red_y <= snap_s) ? '0 : red_y[VEL_W-1:0];

  logic signed [KW_W-1:0] kw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decay_mul) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
    if (cmd_i.kw_mul) begin
      kw_q <= KW_W'(prod_kw >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_x_q    <= '0;
      speed_y_q    <= '0;
      speed_turn_q <= '0;
      brake_q      <= 1'b0;
    end else begin
      if (cmd_i.load_vel) begin
        speed_x_q    <= vel_x_i;
        speed_y_q    <= vel_y_i;
        speed_turn_q <= yaw_rate_i;
      end else if (cmd_i.decay_apply) begin
        speed_x_q    <= new_x;
        speed_y_q    <= new_y;
        speed_turn_q <= '0;
      end
      if (cmd_i.set_brake) begin
        brake_q <= 1'b1;
      end else if (cmd_i.decay_apply && new_x == '0 && new_y == '0) begin
        brake_q <= 1'b0;
      end
    end
  end

  // Divisor of the selected wheel
  logic signed [DIV_W-1:0] sum_s, dif_s, kw_s, dvs_s;

  assign sum_s = DIV_W'(speed_x_q) + DIV_W'(speed_y_q);
  assign dif_s = DIV_W'(speed_x_q) - DIV_W'(speed_y_q);
  assign kw_s  = DIV_W'(kw_q);

  always_comb begin
    case (cmd_i.lane)
      2'd0:    dvs_s = sum_s - kw_s;
      2'd1:    dvs_s = dif_s - kw_s;
      2'd2:    dvs_s = dif_s + kw_s;
      default: dvs_s = sum_s + kw_s;
    endcase
  end

  // Restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0] dvs_q, rem_q;
  logic [NUM_W-1:0] quo_q;
  logic             neg_q, zero_q;
  logic [DIV_W:0]   trial, diff;
  logic             fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvs_q  <= dvs_s[DIV_W-1] ? DIV_W'(-dvs_s) : DIV_W'(dvs_s);
      neg_q  <= dvs_s[DIV_W-1];
      zero_q <= (dvs_s == '0);
      rem_q  <= '0;
      quo_q  <= {circumf_q, FRAC_BITS'(0)};
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  // Saturate, sign and stage the wheel value
  logic [31:0]               quo_ext;
  logic [MAG_W-1:0]          mag;
  logic signed [WHEEL_W-1:0] wheel_val;

  assign quo_ext   = 32'(quo_q);
  assign mag       = (quo_ext > 32'(WHEEL_MAX)) ? WHEEL_MAX : quo_ext[MAG_W-1:0];
  assign wheel_val = zero_q ? '0 :
                     neg_q  ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  logic signed [WHEEL_W-1:0] res_q [4];
  logic signed [WHEEL_W-1:0] out_q [4];
  logic                      out_brake_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      res_q[cmd_i.lane] <= wheel_val;
    end
    if (cmd_i.out_load) begin
      out_q       <= res_q;
      out_brake_q <= brake_q;
    end
  end

  assign wheel_one_o   = out_q[0];
  assign wheel_two_o   = out_q[1];
  assign wheel_three_o = out_q[2];
  assign wheel_four_o  = out_q[3];
  assign braking_o     = out_brake_q;

endmodule

`default_nettype wire

// ===== rtl/core/mecanum_wheel_mixer_with_brake_ramp_unit.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | opcode, vel_x, vel_y, yaw_rate
// out     | output    | out_valid_o/out_ready_i | wheel_one..wheel_four, braking
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index, cfg_data
//
// Items: one item at a time. A drive item, or a tick while braking, runs the
//   shared restoring divider, one quotient bit per cycle, once for each of the
//   four wheels. Brake-start items and idle ticks skip the divider.
// Reset: clears velocity, brake flag and the output valid flag; the config
//   registers return to their defaults.
// Stalls: a finished result waits in the output register while the next item
//   is taken; the next result waits for the previous one to be delivered.
`default_nettype none

module mecanum_wheel_mixer_with_brake_ramp_unit
  import mwm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Items in
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [OP_W-1:0]          opcode_i,
  input  wire logic signed [VEL_W-1:0]  vel_x_i,
  input  wire logic signed [VEL_W-1:0]  vel_y_i,
  input  wire logic signed [VEL_W-1:0]  yaw_rate_i,
  // Results out
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [WHEEL_W-1:0]     wheel_one_o,
  output logic signed [WHEEL_W-1:0]     wheel_two_o,
  output logic signed [WHEEL_W-1:0]     wheel_three_o,
  output logic signed [WHEEL_W-1:0]     wheel_four_o,
  output logic                          braking_o,
  // Configuration writes
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CIDX_W-1:0]        cfg_index_i,
  input  wire logic [REG_W-1:0]         cfg_data_i
);

  mwm_cmd_t cmd;
  mwm_sts_t sts;

  // Config writes are registered directly and always taken.
  assign cfg_ready_o = 1'b1;

  // Controller: sequences load, brake decay, k*w product and the four divides.
  mwm_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: state, config registers, multipliers, divider, result register.
  mwm_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .vel_x_i       (vel_x_i),
    .vel_y_i       (vel_y_i),
    .yaw_rate_i    (yaw_rate_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .wheel_one_o   (wheel_one_o),
    .wheel_two_o   (wheel_two_o),
    .wheel_three_o (wheel_three_o),
    .wheel_four_o  (wheel_four_o),
    .braking_o     (braking_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  import mwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcode the block leaves unused
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint WHEEL_LIMIT = 16777215;
  // Wait longer than the slowest item before touching registers
  localparam int unsigned SETTLE_CYCLES = 150;

  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic signed [WHEEL_W-1:0] wheel_t;

  // One wheel result as the block should emit it
  typedef struct {
    wheel_t one;
    wheel_t two;
    wheel_t three;
    wheel_t four;
    logic   braking;
  } wheel_set_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OP_W-1:0]     opcode_i;
  vel_t                vel_x_i;
  vel_t                vel_y_i;
  vel_t                yaw_rate_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  wheel_t              wheel_one_o;
  wheel_t              wheel_two_o;
  wheel_t              wheel_three_o;
  wheel_t              wheel_four_o;
  logic                braking_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CIDX_W-1:0]   cfg_index_i;
  logic [REG_W-1:0]    cfg_data_i;

  mecanum_wheel_mixer_with_brake_ramp_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .vel_x_i       (vel_x_i),
    .vel_y_i       (vel_y_i),
    .yaw_rate_i    (yaw_rate_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .wheel_one_o   (wheel_one_o),
    .wheel_two_o   (wheel_two_o),
    .wheel_three_o (wheel_three_o),
    .wheel_four_o  (wheel_four_o),
    .braking_o     (braking_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor copy of the registers and the chassis state
  logic [REG_W-1:0] k_track = HALF_TRACK_RST;
  logic [REG_W-1:0] circ    = CIRCUMF_RST;
  logic [REG_W-1:0] decay   = DECAY_RST;
  logic [REG_W-1:0] snap    = SNAP_RST;
  vel_t             spd_x    = '0;
  vel_t             spd_y    = '0;
  vel_t             spd_turn = '0;
  logic             brk      = 1'b0;

  wheel_set_t  pending_wheels[$];
  int unsigned errors   = 0;
  int unsigned applied  = 0;  // items that changed state or emitted a result
  int unsigned checked  = 0;  // wheel results compared
  int unsigned settings = 0;  // register settings run through
  bit          steady   = 1'b0; // no idling on either side while set

  // circumference / divisor, truncated, saturated; zero divisor gives zero
  function automatic wheel_t wheel_of(longint divisor);
    longint q;
    if (divisor == 0) return '0;
    q = (longint'(circ) <<< FRAC) / divisor;
    if (q > WHEEL_LIMIT) q = WHEEL_LIMIT;
    if (q < -WHEEL_LIMIT) q = -WHEEL_LIMIT;
    return q[WHEEL_W-1:0];
  endfunction

  function automatic void queue_wheels();
    longint kw, sum, dif;
    wheel_set_t ws;
    // arithmetic shift on a signed product is the floor
    kw  = (longint'(k_track) * longint'(spd_turn)) >>> FRAC;
    sum = longint'(spd_x) + longint'(spd_y);
    dif = longint'(spd_x) - longint'(spd_y);
    ws.one     = wheel_of(sum - kw);
    ws.two     = wheel_of(dif - kw);
    ws.three   = wheel_of(dif + kw);
    ws.four    = wheel_of(sum + kw);
    ws.braking = brk;
    pending_wheels.push_back(ws);
  endfunction

  // One brake tick on one axis; negatives always land under the snap level
  function automatic vel_t brake_decay(vel_t v);
    longint r;
    r = longint'(v) - ((longint'(decay) * longint'(v)) >>> FRAC);
    if (r <= longint'(snap)) r = 0;
    return vel_t'(r);
  endfunction

  function automatic void apply_item(logic [OP_W-1:0] op, vel_t vx, vel_t vy, vel_t w);
    case (op)
      OP_DRIVE: begin
        spd_x = vx;
        spd_y = vy;
        spd_turn = w;
        applied++;
        queue_wheels();
      end
      OP_BRAKE: begin
        brk = 1'b1;
        applied++;
      end
      OP_TICK: begin
        if (brk) begin
          spd_x = brake_decay(spd_x);
          spd_y = brake_decay(spd_y);
          spd_turn = '0;
          if (spd_x == 0 && spd_y == 0) brk = 1'b0;
          applied++;
          queue_wheels();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // Result checker, samples the pre-edge values
  always @(posedge clk_i) begin : watch_results
    wheel_set_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_wheels.size() == 0) begin
        $error("wheel result arrived with nothing pending");
        errors++;
      end else begin
        want = pending_wheels.pop_front();
        check_field("wheel_one", want.one, wheel_one_o);
        check_field("wheel_two", want.two, wheel_two_o);
        check_field("wheel_three", want.three, wheel_three_o);
        check_field("wheel_four", want.four, wheel_four_o);
        check_field("braking", want.braking, braking_o);
        checked++;
      end
    end
  end

  // Result side back-pressure, ready low at random (odds 27 in 100) unless steady
  always @(posedge clk_i) out_ready_i <= steady || ($urandom_range(99) >= 27);

  // Holds valid across back-to-back items; random gaps, skipped while steady, drop it
  task automatic send_item(input logic [OP_W-1:0] op, input vel_t vx, input vel_t vy,
                           input vel_t w);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    vel_x_i    <= vx;
    vel_y_i    <= vy;
    yaw_rate_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_item(op, vx, vy, w);
  endtask

  // Sender holds off until every pending wheel result is out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then let a no-result item still in flight finish
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_HALF_TRACK: k_track = val;
      REG_CIRCUMF:    circ = val;
      REG_DECAY:      decay = val;
      REG_SNAP:       snap = val;
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [REG_W-1:0] k, input logic [REG_W-1:0] c,
                              input logic [REG_W-1:0] d, input logic [REG_W-1:0] s);
    settle();
    write_reg(REG_HALF_TRACK, k);
    write_reg(REG_CIRCUMF, c);
    write_reg(REG_DECAY, d);
    write_reg(REG_SNAP, s);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  function automatic logic [REG_W-1:0] rand_reg();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return REG_W'($urandom);
    endcase
  endfunction

  // Mix of full range, small values (small divisors), extremes and near zero
  function automatic vel_t rand_vel();
    case ($urandom_range(9))
      0, 1, 2, 3: return vel_t'($urandom);
      4, 5, 6:    return vel_t'(int'($urandom_range(600)) - 300);
      7:          return vel_t'(int'($urandom_range(8000)) - 4000);
      8:          return $urandom_range(1) ? vel_t'(16'sh7FFF) : vel_t'(16'sh8000);
      default:    return vel_t'(int'($urandom_range(2)) - 1);
    endcase
  endfunction

  task automatic drive_random();
    vel_t vx, vy, w;
    vx = rand_vel();
    vy = rand_vel();
    w  = rand_vel();
    // steer some drives onto zero divisors
    case ($urandom_range(11))
      0: begin
        vy = -vx;
        w = '0;
      end
      1: begin
        vy = vx;
        w = '0;
      end
      2: begin
        w = vel_t'(int'($urandom_range(4000)) - 2000);
        vy = '0;
        vx = vel_t'((longint'(k_track) * longint'(w)) >>> FRAC);
      end
      default: ;
    endcase
    send_item(OP_DRIVE, vx, vy, w);
  endtask

  task automatic test_drive_extremes();
    send_item(OP_DRIVE, '0, '0, '0);  // every divisor zero
    send_item(OP_DRIVE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_item(OP_DRIVE, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(OP_DRIVE, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_item(OP_DRIVE, 16'sd1, '0, '0);  // smallest divisor, largest wheel value
    send_item(OP_DRIVE, 16'sd100, -16'sd100, '0);  // wheels one and four divide by zero
    send_item(OP_TICK, rand_vel(), rand_vel(), rand_vel());  // not braking: ignored
    send_item(OP_UNUSED, rand_vel(), rand_vel(), rand_vel());
  endtask

  task automatic test_brake_ramp();
    send_item(OP_DRIVE, 16'sd50, -16'sd5000, 16'sd300);
    send_item(OP_BRAKE, rand_vel(), rand_vel(), rand_vel());
    // drive while braking keeps the flag
    send_item(OP_DRIVE, 16'sd40, 16'sd45, 16'sd7);
    while (brk) send_item(OP_TICK, rand_vel(), rand_vel(), rand_vel());
    send_item(OP_TICK, rand_vel(), rand_vel(), rand_vel());
    // brake start twice, then a tick from standstill clears at once
    send_item(OP_BRAKE, rand_vel(), rand_vel(), rand_vel());
    send_item(OP_BRAKE, rand_vel(), rand_vel(), rand_vel());
    send_item(OP_TICK, rand_vel(), rand_vel(), rand_vel());
    drain();
  endtask

  task automatic test_config_extremes();
    write_config('0, '0, '0, '0);
    send_item(OP_DRIVE, 16'sd300, -16'sd7, 16'sh7FFF);  // zero circumference
    send_item(OP_BRAKE, rand_vel(), rand_vel(), rand_vel());
    send_item(OP_TICK, rand_vel(), rand_vel(), rand_vel());  // no decay, vy snaps
    write_config('1, '1, '1, '1);
    send_item(OP_DRIVE, 16'sd1, '0, '0);
    send_item(OP_DRIVE, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_item(OP_TICK, rand_vel(), rand_vel(), rand_vel());
    write_config(HALF_TRACK_RST, CIRCUMF_RST, DECAY_RST, SNAP_RST);
  endtask

  // Mostly drive / brake / tick runs with random content, the rest noise
  task automatic run_phase(input int unsigned target);
    int unsigned stop_at;
    int unsigned n;
    stop_at = applied + target;
    while (applied < stop_at) begin
      if ($urandom_range(99) < 80) begin
        drive_random();
        if ($urandom_range(3) != 0) begin
          send_item(OP_BRAKE, rand_vel(), rand_vel(), rand_vel());
          n = ($urandom_range(9) < 3) ? 300 : $urandom_range(30, 1);
          while (brk && n != 0) begin
            if ($urandom_range(24) == 0) drive_random();
            else send_item(OP_TICK, rand_vel(), rand_vel(), rand_vel());
            n--;
          end
        end
      end else begin
        send_item(OP_W'($urandom_range(3)), rand_vel(), rand_vel(), rand_vel());
      end
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      if (p == 0) write_config(HALF_TRACK_RST, CIRCUMF_RST, DECAY_RST, SNAP_RST);
      else write_config(rand_reg(), rand_reg(), rand_reg(), rand_reg());
      steady = (p == 2);  // one long stretch with no idling
      run_phase(250);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_DRIVE;
    vel_x_i     = '0;
    vel_y_i     = '0;
    yaw_rate_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_HALF_TRACK;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_drive_extremes();
    test_brake_ramp();
    test_config_extremes();
    test_random();
    settle();

    $display("covered %0d drive, brake-start and active tick items, %0d wheel results checked",
             applied, checked);
    $display("over %0d register settings, with idle ticks and unused opcodes mixed in",
             settings);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mwm_pkg.sv
rtl/core/mwm_ctrl.sv
rtl/core/mwm_datapath.sv
rtl/core/mecanum_wheel_mixer_with_brake_ramp_unit.sv
tb/tb.sv
